FILE: rtl/broadcast_interval_with_duty_floor_macros.svh
// assertion macros for the beacon interval block
`ifndef BROADCAST_INTERVAL_WITH_DUTY_FLOOR_MACROS_SVH
`define BROADCAST_INTERVAL_WITH_DUTY_FLOOR_MACROS_SVH

// same-cycle implication, quiet during reset
`define BIDF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define BIDF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bidf_pkg.sv
// shared constants for the beacon interval block
`timescale 1ns / 1ps
package bidf_pkg;
  localparam int DivSteps = 17;

  typedef enum logic [2:0] {
    REG_MIN_INTERVAL = 3'd0,
    REG_MAX_INTERVAL = 3'd1,
    REG_DUTY_PERCENT = 3'd2,
    REG_LOAD_FRACTION = 3'd3,
    REG_JITTER_FRACTION = 3'd4
  } reg_index_t;

  localparam logic [15:0] MinReset = 16'd100;
  localparam logic [15:0] MaxReset = 16'd5000;
  localparam logic [25:0] DefaultLoadDen = 26'd3000;
  localparam logic [17:0] DelayMax = 18'd262143;

  // flags and jitter factor that ride along the divider chain
  typedef struct packed {
    logic below;
    logic above;
    logic dzero;
    logic signed [35:0] factor;
  } side_t;
endpackage

FILE: rtl/broadcast_interval_with_duty_floor.sv
// Beacon interval with clamps, duty floor and jitter, one result per input transfer.
// Pipeline: 3 setup, 17 divider and 3 output stages from input transfer to result.
// Throughput: one item per cycle; the pipeline holds in place while the result is not taken.
// The latency is set by the 17-stage restoring divider, one quotient bit per stage.
// Reset (rst, synchronous) empties the pipeline and loads min 100, max 5000, others 0.
`timescale 1ns / 1ps
`include "broadcast_interval_with_duty_floor_macros.svh"
module broadcast_interval_with_duty_floor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // peer_count[7:0], airtime_us[27:8], random_fraction[43:28]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // base_interval[16:0], jittered_delay[34:17]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [16:0] cfg_wdata
);
  localparam int NS = bidf_pkg::DivSteps;

  logic [15:0] min_interval, max_interval, load_fraction;
  logic [6:0]  duty_percent;
  logic [16:0] jitter_fraction;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval    <= bidf_pkg::MinReset;
      max_interval    <= bidf_pkg::MaxReset;
      duty_percent    <= '0;
      load_fraction   <= '0;
      jitter_fraction <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bidf_pkg::REG_MIN_INTERVAL:    min_interval <= cfg_wdata[15:0];
        bidf_pkg::REG_MAX_INTERVAL:    max_interval <= cfg_wdata[15:0];
        bidf_pkg::REG_DUTY_PERCENT:    duty_percent <= cfg_wdata[6:0];
        bidf_pkg::REG_LOAD_FRACTION:   load_fraction <= cfg_wdata[15:0];
        bidf_pkg::REG_JITTER_FRACTION: jitter_fraction <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  logic [7:0]  in_peers;
  logic [19:0] in_air;
  logic [15:0] in_r;
  assign in_peers = s_tdata[7:0];
  assign in_air   = s_tdata[27:8];
  assign in_r     = s_tdata[43:28];

  // stage 1: peer product, divisor, jitter factor
  logic               s1_v, s1_def;
  logic [27:0]        s1_count;
  logic [25:0]        s1_d;
  logic [19:0]        s1_air;
  logic [6:0]         s1_duty;
  logic signed [35:0] s1_fac;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= s_tvalid;
    if (adv) begin
      s1_count <= (28'(in_peers) + 28'd1) * 28'(in_air);
      s1_def   <= (load_fraction == '0);
      s1_d     <= (load_fraction == '0) ? bidf_pkg::DefaultLoadDen
                                        : 26'(load_fraction) * 26'd1000;
      s1_air   <= in_air;
      s1_duty  <= duty_percent;
      s1_fac   <= 36'sh1_0000_0000
                + ($signed({1'b0, in_r, 1'b0}) - 18'sd65536) * $signed({1'b0, jitter_fraction});
    end
  end

  // stage 2: scaled numerator and clamp bounds
  logic               s2_v;
  logic [43:0]        s2_n;
  logic [25:0]        s2_d;
  logic [41:0]        s2_lod, s2_hid;
  logic [19:0]        s2_air;
  logic [6:0]         s2_duty;
  logic signed [35:0] s2_fac;

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v;
    if (adv) begin
      s2_n    <= s1_def ? 44'(s1_count) * 44'd20 : {s1_count, 16'd0};
      s2_d    <= s1_d;
      s2_lod  <= 42'(min_interval) * 42'(s1_d);
      s2_hid  <= 42'(max_interval) * 42'(s1_d);
      s2_air  <= s1_air;
      s2_duty <= s1_duty;
      s2_fac  <= s1_fac;
    end
  end

  // divider chain: rounding quotient (2n+d)/(2d) and duty floor (a+5d)/(10d)
  logic [NS:0]        dv_v;
  logic [44:0]        rb  [NS+1];
  logic [26:0]        db  [NS+1];
  logic [16:0]        qb  [NS+1];
  logic [20:0]        rd  [NS+1];
  logic [10:0]        dd  [NS+1];
  logic [16:0]        qd  [NS+1];
  bidf_pkg::side_t    sd  [NS+1];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (adv) dv_v[0] <= s2_v;
    if (adv) begin
      rb[0] <= {s2_n, 1'b0} + 45'(s2_d);
      db[0] <= {s2_d, 1'b0};
      qb[0] <= '0;
      rd[0] <= 21'(s2_air) + 21'(s2_duty) * 21'd5;
      dd[0] <= 11'(s2_duty) * 11'd10;
      qd[0] <= '0;
      sd[0].below  <= ({2'b0, s2_lod} > s2_n);
      sd[0].above  <= (s2_n > {2'b0, s2_hid});
      sd[0].dzero  <= (s2_duty == '0);
      sd[0].factor <= s2_fac;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_div
    localparam int Sh = NS - 1 - k;
    logic [44:0] tb;
    logic [27:0] td;
    logic        gb, gd;
    assign tb = 45'(db[k]) << Sh;
    assign td = 28'(dd[k]) << Sh;
    assign gb = (rb[k] >= tb);
    assign gd = ({7'd0, rd[k]} >= td);
    always_ff @(posedge clk) begin
      if (rst) dv_v[k+1] <= 1'b0;
      else if (adv) dv_v[k+1] <= dv_v[k];
      if (adv) begin
        rb[k+1] <= gb ? rb[k] - tb : rb[k];
        db[k+1] <= db[k];
        qb[k+1] <= {qb[k][15:0], gb};
        rd[k+1] <= gd ? 21'(28'(rd[k]) - td) : rd[k];
        dd[k+1] <= dd[k];
        qd[k+1] <= {qd[k][15:0], gd};
        sd[k+1] <= sd[k];
      end
    end
  end

  // output stage 1: clamp and duty floor
  logic        m1_v, m1_pos;
  logic [16:0] m1_base;
  logic [33:0] m1_f;
  logic [15:0] clamped;
  logic [16:0] dfloor;

  always_comb begin
    priority if (sd[NS].below) clamped = min_interval;
    else if (sd[NS].above)     clamped = max_interval;
    else                       clamped = qb[NS][15:0];
    dfloor = sd[NS].dzero ? '0 : qd[NS];
  end

  always_ff @(posedge clk) begin
    if (rst) m1_v <= 1'b0;
    else if (adv) m1_v <= dv_v[NS];
    if (adv) begin
      m1_base <= ({1'b0, clamped} > dfloor) ? {1'b0, clamped} : dfloor;
      m1_pos  <= (sd[NS].factor > 36'sd0);
      m1_f    <= sd[NS].factor[33:0];
    end
  end

  // output stage 2: split product
  logic        m2_v, m2_pos;
  logic [16:0] m2_base;
  logic [33:0] m2_pl, m2_ph;

  always_ff @(posedge clk) begin
    if (rst) m2_v <= 1'b0;
    else if (adv) m2_v <= m1_v;
    if (adv) begin
      m2_pl   <= 34'(m1_base) * 34'(m1_f[16:0]);
      m2_ph   <= 34'(m1_base) * 34'(m1_f[33:17]);
      m2_pos  <= m1_pos;
      m2_base <= m1_base;
    end
  end

  // output stage 3: round half up and saturate, zero delay for a non-positive factor
  logic [50:0] prod;
  logic [18:0] q;
  logic [17:0] jit;
  assign prod = {m2_ph, 17'd0} + 51'(m2_pl) + 51'h8000_0000;
  assign q    = prod[50:32];
  assign jit  = !m2_pos ? '0 : (q > 19'(bidf_pkg::DelayMax)) ? bidf_pkg::DelayMax : q[17:0];

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= m2_v;
    if (adv) m_tdata <= {5'd0, jit, m2_base};
  end

  `BIDF_ASSERT_NXT(a_hold_on_stall, clk, rst, !adv, $stable(dv_v) && $stable(m_tdata), "pipeline moved while stalled")
  `BIDF_ASSERT_NXT(a_below_min, clk, rst, adv && dv_v[NS] && sd[NS].below, m1_base >= {1'b0, min_interval}, "base under minimum")
  `BIDF_ASSERT_NXT(a_no_duty, clk, rst, adv && dv_v[NS] && sd[NS].dzero, m1_base == {1'b0, $past(clamped)}, "duty floor applied with no duty")
endmodule

FILE: tb/testbench.sv
// self-checking testbench for the beacon interval block
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic [15:0] rnd;
    logic [19:0] airtime;
    logic [7:0]  peers;
  } beacon_req_t;

  typedef struct packed {
    logic [17:0] delay;
    logic [16:0] base;
  } beacon_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;  // peer_count, airtime_us, random_fraction
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;       // base_interval, jittered_delay
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [16:0] cfg_wdata = '0;

  broadcast_interval_with_duty_floor dut (.*);

  always #10 clk = ~clk;

  // predictor copy of the registers
  logic [15:0] p_min = 16'd100, p_max = 16'd5000, p_load = '0;
  logic [6:0]  p_duty = '0;
  logic [16:0] p_jit = '0;

  beacon_req_t pending_reqs[$];
  beacon_res_t expected_results[$];
  int mismatches = 0;
  longint cycles = 0;
  bit stim_done = 0;
  bit s_taken = 0;

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic beacon_res_t interval_of(beacon_req_t q);
    logic [127:0] n, d, cnt, base, dfl, q2;
    logic signed [63:0] factor;
    logic [127:0] prod;
    beacon_res_t r;
    cnt = 128'(q.peers + 1) * 128'(q.airtime);
    if (p_load == 0) begin
      n = cnt * 20; d = 3000;
    end else begin
      n = cnt * 65536; d = 128'(p_load) * 1000;
    end
    if (n < 128'(p_min) * d) base = p_min;
    else if (n > 128'(p_max) * d) base = p_max;
    else base = (2 * n + d) / (2 * d);
    dfl = (p_duty == 0 || q.airtime == 0) ? 0
        : (128'(q.airtime) + 5 * p_duty) / (10 * p_duty);
    if (dfl > base) base = dfl;
    factor = 64'sh1_0000_0000 + (2 * $signed({1'b0, 47'(q.rnd)}) - 65536)
             * $signed({1'b0, 47'(p_jit)});
    if (factor <= 0) q2 = 0;
    else begin
      prod = base * 128'(factor);
      q2 = (prod + 128'h8000_0000) >> 32;
      if (q2 > 262143) q2 = 262143;
    end
    r.base = base[16:0];
    r.delay = q2[17:0];
    return r;
  endfunction

  // driver
  int s_gap = 0;
  int m_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (s_taken) begin
        s_gap = gap_len();
        if (s_gap == 0 && pending_reqs.size() > 0) begin
          s_tdata <= {4'b0, pending_reqs.pop_front()};
          s_tvalid <= 1'b1;
        end else s_tvalid <= 1'b0;
      end else if (!s_tvalid) begin
        if (s_gap > 0) s_gap--;
        else if (pending_reqs.size() > 0) begin
          s_tdata <= {4'b0, pending_reqs.pop_front()};
          s_tvalid <= 1'b1;
        end
      end
      if (m_gap > 0) begin
        m_gap--;
        m_tready <= 1'b0;
      end else begin
        m_gap = gap_len();
        m_tready <= (m_gap == 0);
      end
    end
  end

  // input transfer feeds the predictor
  always @(posedge clk) begin
    s_taken = !rst && s_tvalid && s_tready;
    if (s_taken)
      expected_results.push_back(interval_of(beacon_req_t'(s_tdata[43:0])));
  end

  // monitor
  always @(posedge clk) begin
    beacon_res_t got, exp_r;
    cycles++;
    if (!rst && m_tvalid && m_tready) begin
      got = beacon_res_t'(m_tdata[34:0]);
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result base %0d delay %0d", got.base, got.delay);
      end else begin
        exp_r = expected_results.pop_front();
        if (got.base !== exp_r.base || got.delay !== exp_r.delay) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: base exp %0d got %0d, delay exp %0d got %0d",
                     exp_r.base, got.base, exp_r.delay, got.delay);
        end
      end
    end
  end

  task automatic write_reg(bidf_pkg::reg_index_t idx, logic [16:0] v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bidf_pkg::REG_MIN_INTERVAL:    p_min = v[15:0];
      bidf_pkg::REG_MAX_INTERVAL:    p_max = v[15:0];
      bidf_pkg::REG_DUTY_PERCENT:    p_duty = v[6:0];
      bidf_pkg::REG_LOAD_FRACTION:   p_load = v[15:0];
      bidf_pkg::REG_JITTER_FRACTION: p_jit = v;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic beacon_req_t rand_req();
    beacon_req_t q;
    q.peers = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom_range(0, 40));
    case ($urandom_range(0, 4))
      0: q.airtime = 20'($urandom);
      1: q.airtime = 20'($urandom_range(0, 2000));
      2: q.airtime = 20'hfffff - 20'($urandom_range(0, 3));
      default: q.airtime = 20'($urandom_range(0, 200000));
    endcase
    q.rnd = 16'($urandom);
    return q;
  endfunction

  // settings: min, max, duty, load, jitter
  logic [16:0] settings[6][5] = '{
    '{100, 5000, 0, 0, 0},
    '{0, 65535, 100, 65535, 131071},
    '{65535, 0, 127, 1, 65536},
    '{500, 200, 1, 9830, 32768},
    '{0, 0, 7, 300, 1},
    '{10, 40000, 50, 4096, 100000}};

  initial begin
    beacon_req_t q;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // random requests and directed extremes for each setting, more extremes at reset settings
    foreach (settings[s]) begin
      if (s > 0)
        for (int i = 0; i < 5; i++) write_reg(bidf_pkg::reg_index_t'(i), settings[s][i]);
      if (s == 0) begin
        pending_reqs.push_back('{16'h0, 20'h0, 8'h0});
        pending_reqs.push_back('{16'hffff, 20'hfffff, 8'hff});
        pending_reqs.push_back('{16'h8000, 20'd15000, 8'd2});
        pending_reqs.push_back('{16'h0, 20'd1, 8'd0});
        pending_reqs.push_back('{16'h5555, 20'haaaaa, 8'h55});
        pending_reqs.push_back('{16'haaaa, 20'h55555, 8'haa});
      end
      for (int k = 0; k < 260; k++) pending_reqs.push_back(rand_req());
      pending_reqs.push_back('{16'h0, 20'hfffff, 8'hff});
      pending_reqs.push_back('{16'hffff, 20'h0, 8'h0});
      drain();
    end
    stim_done = 1;
  end

  initial begin
    while (!stim_done && cycles < 400000) @(posedge clk);
    if (!stim_done) $display("broadcast_interval_with_duty_floor verification failed");
    else if (mismatches == 0 && expected_results.size() == 0)
      $display("broadcast_interval_with_duty_floor verification clean");
    else $display("broadcast_interval_with_duty_floor verification failed");
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl
rtl/bidf_pkg.sv
rtl/broadcast_interval_with_duty_floor.sv
tb/testbench.sv
